// ===== hdl/qlfs_pkg.sv =====
// Shared constants, codes and types of the quoted list field splitter.
// No dependencies; used by every module of the block.
package qlfs_pkg;

    localparam int TOKEN_BYTES = 256;
    localparam int MAX_FIELDS  = 32;
    localparam int CHUNK_BYTES = 8;

    localparam int TOK_AW = $clog2(TOKEN_BYTES);
    localparam int CMP_W  = (TOK_AW > 8) ? TOK_AW : 8;
    localparam int CNT_W  = ($clog2(MAX_FIELDS + 1) > 6) ? $clog2(MAX_FIELDS + 1) : 6;
    localparam int CHK_W  = $clog2(CHUNK_BYTES + 1);

    localparam logic [7:0] CH_END   = 8'h00;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_QUOTE = 8'h27;

    localparam logic [2:0] ERR_EMPTY    = 3'd0;
    localparam logic [2:0] ERR_TOO_MANY = 3'd1;
    localparam logic [2:0] ERR_TOO_LONG = 3'd2;
    localparam logic [2:0] ERR_FULL     = 3'd3;
    localparam logic [2:0] ERR_UNTERM   = 3'd4;

    localparam logic CFG_MAX_LEN   = 1'b0;
    localparam logic CFG_MAX_ITEMS = 1'b1;

    // what one accepted byte causes
    typedef struct packed {
        logic              wr_en;
        logic [TOK_AW-1:0] wr_addr;
        logic [7:0]        wr_data;
        logic              err_valid;
        logic [2:0]        err_code;
        logic [4:0]        err_index;
        logic              start;
        logic [TOK_AW-1:0] start_first;
        logic [TOK_AW-1:0] start_len;
        logic [4:0]        start_index;
        logic              start_end;
    } t_scan_evt;

    typedef struct packed {
        logic        is_error;
        logic [63:0] chunk_data;
        logic [3:0]  chunk_bytes;
        logic        field_last;
        logic [4:0]  field_index;
        logic        list_done;
        logic [2:0]  error_code;
    } t_result;

endpackage

// ===== hdl/qlfs_scan.sv =====
// Byte scanner: quote handling, trim tracking, item checks and list state.
// Depends on qlfs_pkg.
module qlfs_scan (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_beat,
    input  logic [7:0]                 i_byte,
    input  logic [7:0]                 i_max_len,
    input  logic [5:0]                 i_max_items,
    output qlfs_pkg::t_scan_evt        o_evt
);

    logic [qlfs_pkg::TOK_AW-1:0] r_len, n_len;
    logic [qlfs_pkg::TOK_AW-1:0] r_first, n_first;
    logic [qlfs_pkg::TOK_AW-1:0] r_last, n_last;
    logic                        r_seen, n_seen;
    logic                        r_in_str, n_in_str;
    logic                        r_qpend, n_qpend;
    logic [qlfs_pkg::CNT_W-1:0]  r_count, n_count;
    logic                        r_discard, n_discard;

    logic                        outside, do_store, do_finish, do_err;
    logic [2:0]                  err_code;
    logic                        blank;
    logic [qlfs_pkg::TOK_AW-1:0] item_len;
    logic [qlfs_pkg::CNT_W-1:0]  limit;

    assign blank = (i_byte == 8'h20) || ((i_byte >= 8'h09) && (i_byte <= 8'h0D));
    assign item_len = r_seen ? (r_last - r_first + qlfs_pkg::TOK_AW'(1))
                             : '0;
    assign limit = (qlfs_pkg::CNT_W'(i_max_items) > qlfs_pkg::CNT_W'(qlfs_pkg::MAX_FIELDS))
                   ? qlfs_pkg::CNT_W'(qlfs_pkg::MAX_FIELDS)
                   : qlfs_pkg::CNT_W'(i_max_items);

    always_comb begin
        n_len     = r_len;
        n_first   = r_first;
        n_last    = r_last;
        n_seen    = r_seen;
        n_in_str  = r_in_str;
        n_qpend   = r_qpend;
        n_count   = r_count;
        n_discard = r_discard;
        outside   = 1'b0;
        do_store  = 1'b0;
        do_finish = 1'b0;
        do_err    = 1'b0;
        err_code  = qlfs_pkg::ERR_EMPTY;
        o_evt     = '0;

        if (i_beat) begin
            if (r_discard) begin
                if (i_byte == qlfs_pkg::CH_END) begin
                    n_len = '0; n_first = '0; n_last = '0; n_seen = 1'b0;
                    n_in_str = 1'b0; n_qpend = 1'b0; n_count = '0; n_discard = 1'b0;
                end
            end else begin
                if (r_in_str) begin
                    if (r_qpend) begin
                        n_qpend = 1'b0;
                        if (i_byte == qlfs_pkg::CH_QUOTE) begin
                            do_store = 1'b1;
                        end else begin
                            n_in_str = 1'b0;
                            outside  = 1'b1;
                        end
                    end else if (i_byte == qlfs_pkg::CH_QUOTE) begin
                        n_qpend = 1'b1;
                    end else if (i_byte == qlfs_pkg::CH_END) begin
                        do_err   = 1'b1;
                        err_code = qlfs_pkg::ERR_UNTERM;
                    end else begin
                        do_store = 1'b1;
                    end
                end else begin
                    outside = 1'b1;
                end

                if (outside) begin
                    if (i_byte == qlfs_pkg::CH_QUOTE) begin
                        n_in_str = 1'b1;
                    end else if (i_byte == qlfs_pkg::CH_COMMA || i_byte == qlfs_pkg::CH_END) begin
                        do_finish = 1'b1;
                    end else begin
                        do_store = 1'b1;
                    end
                end

                if (do_store) begin
                    if (r_len >= qlfs_pkg::TOK_AW'(qlfs_pkg::TOKEN_BYTES - 1)) begin
                        do_err   = 1'b1;
                        err_code = qlfs_pkg::ERR_FULL;
                    end else begin
                        o_evt.wr_en   = 1'b1;
                        o_evt.wr_addr = r_len;
                        o_evt.wr_data = i_byte;
                        if (!blank) begin
                            if (!r_seen) begin
                                n_first = r_len;
                                n_seen  = 1'b1;
                            end
                            n_last = r_len;
                        end
                        n_len = r_len + qlfs_pkg::TOK_AW'(1);
                    end
                end

                if (do_finish) begin
                    if (item_len == '0) begin
                        do_err   = 1'b1;
                        err_code = qlfs_pkg::ERR_EMPTY;
                    end else if (r_count >= limit) begin
                        do_err   = 1'b1;
                        err_code = qlfs_pkg::ERR_TOO_MANY;
                    end else if (qlfs_pkg::CMP_W'(item_len) > qlfs_pkg::CMP_W'(i_max_len)) begin
                        do_err   = 1'b1;
                        err_code = qlfs_pkg::ERR_TOO_LONG;
                    end else begin
                        // token memory keeps its bytes; the reader works from these
                        o_evt.start       = 1'b1;
                        o_evt.start_first = r_first;
                        o_evt.start_len   = item_len;
                        o_evt.start_index = r_count[4:0];
                        o_evt.start_end   = (i_byte == qlfs_pkg::CH_END);
                        n_count = r_count + qlfs_pkg::CNT_W'(1);
                        n_len = '0; n_first = '0; n_last = '0; n_seen = 1'b0;
                        if (i_byte == qlfs_pkg::CH_END) begin
                            n_in_str = 1'b0; n_qpend = 1'b0; n_count = '0;
                            n_discard = 1'b0;
                        end
                    end
                end

                if (do_err) begin
                    o_evt.err_valid = 1'b1;
                    o_evt.err_code  = err_code;
                    o_evt.err_index = (r_count > qlfs_pkg::CNT_W'(31)) ? 5'd31 : r_count[4:0];
                    if (i_byte == qlfs_pkg::CH_END) begin
                        n_len = '0; n_first = '0; n_last = '0; n_seen = 1'b0;
                        n_in_str = 1'b0; n_qpend = 1'b0; n_count = '0;
                        n_discard = 1'b0;
                    end else begin
                        n_discard = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len     <= '0;
            r_first   <= '0;
            r_last    <= '0;
            r_seen    <= 1'b0;
            r_in_str  <= 1'b0;
            r_qpend   <= 1'b0;
            r_count   <= '0;
            r_discard <= 1'b0;
        end else begin
            r_len     <= n_len;
            r_first   <= n_first;
            r_last    <= n_last;
            r_seen    <= n_seen;
            r_in_str  <= n_in_str;
            r_qpend   <= n_qpend;
            r_count   <= n_count;
            r_discard <= n_discard;
        end
    end

endmodule

// ===== hdl/qlfs_chunk_rd.sv =====
// Token memory and chunk reader: stores token bytes, reads a field back
// one byte a cycle within a chunk and assembles chunks. Depends on qlfs_pkg.
module qlfs_chunk_rd (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  qlfs_pkg::t_scan_evt i_evt,
    output logic                o_busy,
    output logic                o_valid,
    input  logic                i_ready,
    output qlfs_pkg::t_result   o_res
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [7:0] mem [qlfs_pkg::TOKEN_BYTES];
    logic [7:0] r_q;

    logic [1:0]                  r_state, n_state;
    logic [qlfs_pkg::TOK_AW-1:0] r_ptr, n_ptr;
    logic [qlfs_pkg::TOK_AW-1:0] r_remain, n_remain;
    logic [qlfs_pkg::CHK_W-1:0]  r_take, n_take;
    logic [qlfs_pkg::CHK_W-1:0]  r_issued, n_issued;
    logic [qlfs_pkg::CHK_W-1:0]  r_fill;
    logic                        r_pend;
    logic [7:0]                  r_lane [qlfs_pkg::CHUNK_BYTES];
    logic [4:0]                  r_index;
    logic                        r_end;

    logic                        issue, new_chunk, chunk_last;
    logic [qlfs_pkg::TOK_AW-1:0] left;

    // writes come only while idle, since the top holds input off while busy; the read port runs every cycle
    always_ff @(posedge i_clk) begin
        if (i_evt.wr_en) begin
            mem[i_evt.wr_addr] <= i_evt.wr_data;
        end
        r_q <= mem[r_ptr];
    end

    assign issue      = (r_state == ST_READ) && (r_issued != r_take);
    assign left       = r_remain - qlfs_pkg::TOK_AW'(r_take);
    assign chunk_last = (left == '0);

    always_comb begin
        n_state   = r_state;
        n_ptr     = issue ? r_ptr + qlfs_pkg::TOK_AW'(1) : r_ptr;
        n_remain  = r_remain;
        n_take    = r_take;
        n_issued  = issue ? r_issued + qlfs_pkg::CHK_W'(1) : r_issued;
        new_chunk = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_evt.start) begin
                    n_state   = ST_READ;
                    n_ptr     = i_evt.start_first;
                    n_remain  = i_evt.start_len;
                    new_chunk = 1'b1;
                end
            end
            ST_READ: begin
                if (r_fill == r_take && !r_pend) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (i_ready) begin
                    n_remain = left;
                    if (chunk_last) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_state   = ST_READ;
                        new_chunk = 1'b1;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
        if (new_chunk) begin
            n_issued = '0;
            n_take   = (n_remain >= qlfs_pkg::TOK_AW'(qlfs_pkg::CHUNK_BYTES))
                       ? qlfs_pkg::CHK_W'(qlfs_pkg::CHUNK_BYTES)
                       : n_remain[qlfs_pkg::CHK_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pend  <= 1'b0;
            r_fill  <= '0;
        end else begin
            r_state <= n_state;
            r_pend  <= issue;
            if (new_chunk) begin
                r_fill <= '0;
            end else if (r_pend) begin
                r_fill <= r_fill + qlfs_pkg::CHK_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr    <= n_ptr;
        r_remain <= n_remain;
        r_take   <= n_take;
        r_issued <= n_issued;
        if (r_state == ST_IDLE && i_evt.start) begin
            r_index <= i_evt.start_index;
            r_end   <= i_evt.start_end;
        end
        for (int k = 0; k < qlfs_pkg::CHUNK_BYTES; k++) begin
            if (new_chunk) begin
                r_lane[k] <= '0;
            end else if (r_pend && r_fill == qlfs_pkg::CHK_W'(k)) begin
                r_lane[k] <= r_q;
            end
        end
    end

    always_comb begin
        o_res             = '0;
        o_res.is_error    = 1'b0;
        for (int k = 0; k < qlfs_pkg::CHUNK_BYTES; k++) begin
            o_res.chunk_data[8*k +: 8] = r_lane[k];
        end
        o_res.chunk_bytes = 4'(r_take);
        o_res.field_last  = chunk_last;
        o_res.field_index = r_index;
        o_res.list_done   = chunk_last && r_end;
        o_res.error_code  = qlfs_pkg::ERR_EMPTY;
    end

    assign o_busy  = (r_state != ST_IDLE);
    assign o_valid = (r_state == ST_EMIT);

endmodule

// ===== hdl/quoted_list_field_splitter_unit.sv =====
// Quoted list field splitter: takes one text byte per beat and returns each
// field, trimmed, as chunks of up to eight bytes, or an error report. A byte
// that ends a valid field stalls input while the field is read back from the
// token memory one byte per cycle, pausing while a chunk waits for the output.
// Errors do not stall the input.
// Depends on qlfs_pkg, qlfs_scan and qlfs_chunk_rd.
module quoted_list_field_splitter_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] text_byte
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [63:0] chunk_data, [67:64] chunk_bytes, [72:68] field_index,
    // [73] list_done, [76:74] error_code, [79:77] zero
    output logic [79:0] o_m_axis_tdata,
    output logic        o_m_axis_tlast,   // field_last
    output logic        o_m_axis_tuser,   // [0] is_error
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    logic [7:0]          r_max_len;
    logic [5:0]          r_max_items;
    logic                r_out_valid;
    qlfs_pkg::t_result   r_out;
    qlfs_pkg::t_scan_evt evt;
    qlfs_pkg::t_result   rd_res;
    qlfs_pkg::t_result   err_res;
    logic                rd_busy, rd_valid, out_free, beat;

    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = !rd_busy && out_free;
    assign beat            = i_s_axis_tvalid && o_s_axis_tready;
    assign o_cfg_ready     = 1'b1;

    qlfs_scan u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_beat      (beat),
        .i_byte      (i_s_axis_tdata),
        .i_max_len   (r_max_len),
        .i_max_items (r_max_items),
        .o_evt       (evt)
    );

    qlfs_chunk_rd u_chunk_rd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_evt   (evt),
        .o_busy  (rd_busy),
        .o_valid (rd_valid),
        .i_ready (out_free),
        .o_res   (rd_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len   <= 8'd255;
            r_max_items <= 6'd32;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                qlfs_pkg::CFG_MAX_LEN:   r_max_len   <= i_cfg_data;
                qlfs_pkg::CFG_MAX_ITEMS: r_max_items <= i_cfg_data[5:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        err_res             = '0;
        err_res.is_error    = 1'b1;
        err_res.field_index = evt.err_index;
        err_res.error_code  = evt.err_code;
    end

    // output register; error reports and chunks never arrive together
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (evt.err_valid || (rd_valid && out_free)) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (evt.err_valid) begin
            r_out <= err_res;
        end else if (rd_valid && out_free) begin
            r_out <= rd_res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {3'b000, r_out.error_code, r_out.list_done, r_out.field_index,
                              r_out.chunk_bytes, r_out.chunk_data};
    assign o_m_axis_tlast  = r_out.field_last;
    assign o_m_axis_tuser  = r_out.is_error;

endmodule

// ===== tb/testbench.sv =====
// Self-checking bench for quoted_list_field_splitter_unit: text bytes in, field chunks
// and error reports out, checked against a built-in scoreboard that predicts every beat.
// Depends on qlfs_pkg and the RTL under hdl/.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE_CYCLES = 400;    // covers the longest field readout
    localparam int HOLD_CYCLES   = 3000;
    localparam int STALL_LIMIT   = 20000;
    localparam int PHASE_BYTES   = 24;

    // Predicts the chunks and error reports of the splitter, beat by beat.
    class splitter_scoreboard;
        logic [7:0]  tok_mem [qlfs_pkg::TOKEN_BYTES];
        int unsigned tok_len;
        int unsigned first_ns;
        int unsigned last_ns;
        int unsigned field_cnt;
        int unsigned len_limit;
        int unsigned count_limit;
        bit          seen_ns;
        bit          in_quote;
        bit          quote_seen;
        bit          dropping;
        qlfs_pkg::t_result chunk_q[$];
        int unsigned fail_cnt;

        function new();
            len_limit   = 255;
            count_limit = 32;
            fail_cnt    = 0;
            reset_list();
        endfunction

        function void clear_token();
            tok_len  = 0;
            first_ns = 0;
            last_ns  = 0;
            seen_ns  = 0;
        endfunction

        function void reset_list();
            clear_token();
            in_quote   = 0;
            quote_seen = 0;
            field_cnt  = 0;
            dropping   = 0;
        endfunction

        function void set_reg(logic idx, logic [7:0] val);
            if (idx == qlfs_pkg::CFG_MAX_LEN)
                len_limit = val;
            else
                count_limit = val & 8'h3F;
        endfunction

        function void raise_error(logic [2:0] code, logic [7:0] c);
            qlfs_pkg::t_result r;
            r             = '0;
            r.is_error    = 1'b1;
            r.field_index = (field_cnt > 31) ? 5'd31 : 5'(field_cnt);
            r.error_code  = code;
            chunk_q.push_back(r);
            if (c == qlfs_pkg::CH_END)
                reset_list();
            else
                dropping = 1;
        endfunction

        function void keep_char(logic [7:0] c);
            if (tok_len + 1 >= qlfs_pkg::TOKEN_BYTES) begin
                raise_error(qlfs_pkg::ERR_FULL, c);
                return;
            end
            if (!(c == 8'h20 || (c >= 8'h09 && c <= 8'h0D))) begin
                if (!seen_ns) begin
                    first_ns = tok_len;
                    seen_ns  = 1;
                end
                last_ns = tok_len;
            end
            tok_mem[tok_len] = c;
            tok_len++;
        endfunction

        function void close_field(logic [7:0] c);
            qlfs_pkg::t_result r;
            int unsigned flen;
            int unsigned lim;
            int unsigned pos;
            int unsigned take;
            flen = seen_ns ? last_ns - first_ns + 1 : 0;
            lim  = (count_limit < qlfs_pkg::MAX_FIELDS) ? count_limit : qlfs_pkg::MAX_FIELDS;
            if (flen == 0)
                raise_error(qlfs_pkg::ERR_EMPTY, c);
            else if (field_cnt >= lim)
                raise_error(qlfs_pkg::ERR_TOO_MANY, c);
            else if (flen > len_limit)
                raise_error(qlfs_pkg::ERR_TOO_LONG, c);
            else begin
                pos = 0;
                while (pos < flen) begin
                    take = (flen - pos > qlfs_pkg::CHUNK_BYTES) ? qlfs_pkg::CHUNK_BYTES
                                                                : flen - pos;
                    r    = '0;
                    for (int j = 0; j < take; j++)
                        r.chunk_data[8*j +: 8] =
                            tok_mem[(first_ns + pos + j) % qlfs_pkg::TOKEN_BYTES];
                    pos           += take;
                    r.chunk_bytes  = 4'(take);
                    r.field_last   = (pos >= flen);
                    r.field_index  = 5'(field_cnt);
                    r.list_done    = r.field_last && (c == qlfs_pkg::CH_END);
                    chunk_q.push_back(r);
                end
                field_cnt++;
                clear_token();
                if (c == qlfs_pkg::CH_END)
                    reset_list();
            end
        endfunction

        function void note_byte(logic [7:0] c);
            if (dropping) begin
                if (c == qlfs_pkg::CH_END)
                    reset_list();
                return;
            end
            if (in_quote) begin
                if (quote_seen) begin
                    quote_seen = 0;
                    if (c == qlfs_pkg::CH_QUOTE) begin
                        keep_char(c);     // doubled quote: one quote is data
                        return;
                    end
                    in_quote = 0;         // string closed, byte handled as plain
                end else begin
                    if (c == qlfs_pkg::CH_QUOTE) begin
                        quote_seen = 1;
                        return;
                    end
                    if (c == qlfs_pkg::CH_END) begin
                        raise_error(qlfs_pkg::ERR_UNTERM, c);
                        return;
                    end
                    keep_char(c);
                    return;
                end
            end
            if (c == qlfs_pkg::CH_QUOTE)
                in_quote = 1;
            else if (c == qlfs_pkg::CH_COMMA || c == qlfs_pkg::CH_END)
                close_field(c);
            else
                keep_char(c);
        endfunction

        function string show(qlfs_pkg::t_result r);
            return $sformatf("err=%0b data=%h bytes=%0d last=%0b idx=%0d done=%0b code=%0d",
                r.is_error, r.chunk_data, r.chunk_bytes, r.field_last, r.field_index,
                r.list_done, r.error_code);
        endfunction

        function void check(qlfs_pkg::t_result got);
            qlfs_pkg::t_result want;
            if (chunk_q.size() == 0) begin
                fail_cnt++;
                $display("%0t: unexpected beat, actual %s", $time, show(got));
                return;
            end
            want = chunk_q.pop_front();
            if (got !== want) begin
                fail_cnt++;
                $display("%0t: mismatch, expected %s, actual %s", $time, show(want), show(got));
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n         = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [7:0]  i_s_axis_tdata  = '0;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [79:0] o_m_axis_tdata;
    logic        o_m_axis_tlast;
    logic        o_m_axis_tuser;
    logic        i_cfg_valid     = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_index     = 1'b0;
    logic [7:0]  i_cfg_data      = '0;

    splitter_scoreboard sb = new();
    logic [7:0]  text_q[$];
    int          send_idle_pct = 0;
    int          stall_pct     = 0;
    int          hold_seq      = 0;
    int          hold_seen     = 0;
    int          hold_left     = 0;
    int          sent_cnt      = 0;
    int          quiet_cycles  = 0;

    quoted_list_field_splitter_unit DUT (.*);

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // receiver: random stalls plus an occasional long hold-off
    always @(posedge i_clk) begin
        if (hold_seq != hold_seen) begin
            hold_seen = hold_seq;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_m_axis_tready <= 1'b0;
        end else
            i_m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // monitor: all handshakes sampled at the same edge, inputs noted before outputs
    always @(posedge i_clk) begin
        qlfs_pkg::t_result got;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready)
                sb.set_reg(i_cfg_index, i_cfg_data);
            if (i_s_axis_tvalid && o_s_axis_tready)
                sb.note_byte(i_s_axis_tdata);
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                got.is_error    = o_m_axis_tuser;
                got.chunk_data  = o_m_axis_tdata[63:0];
                got.chunk_bytes = o_m_axis_tdata[67:64];
                got.field_last  = o_m_axis_tlast;
                got.field_index = o_m_axis_tdata[72:68];
                got.list_done   = o_m_axis_tdata[73];
                got.error_code  = o_m_axis_tdata[76:74];
                sb.check(got);
            end
            if ((i_cfg_valid && o_cfg_ready) || (i_s_axis_tvalid && o_s_axis_tready) ||
                (o_m_axis_tvalid && i_m_axis_tready))
                quiet_cycles = 0;
            else if (++quiet_cycles >= STALL_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    function automatic logic [7:0] rnd_blank();
        int r;
        r = $urandom_range(0, 5);
        return (r == 5) ? 8'h20 : 8'(8'h09 + r);
    endfunction

    function automatic logic [7:0] rnd_char();
        int         r;
        logic [7:0] c;
        r = $urandom_range(0, 99);
        if (r < 15)
            c = rnd_blank();
        else if (r < 30)
            c = 8'($urandom_range(128, 255));
        else begin
            c = 8'($urandom_range(33, 126));
            if (c == qlfs_pkg::CH_QUOTE || c == qlfs_pkg::CH_COMMA)
                c = "_";
        end
        return c;
    endfunction

    function automatic void add_byte(logic [7:0] b);
        text_q.push_back(b);
    endfunction

    function automatic void add_str(string s);
        for (int k = 0; k < s.len(); k++)
            text_q.push_back(s[k]);
    endfunction

    // valid stays high after a beat; the next call or a drain decides what follows
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= b;
        do @(posedge i_clk); while (!o_s_axis_tready);
        sent_cnt++;
    endtask

    task automatic send_text();
        foreach (text_q[k])
            send_byte(text_q[k]);
        text_q.delete();
    endtask

    // wait on the clock first so the monitor has noted the last beat
    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.chunk_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [7:0] val);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic add_field();
        int n;
        int r;
        repeat ($urandom_range(0, 2)) add_byte(rnd_blank());
        r = $urandom_range(0, 99);
        n = (r < 1) ? $urandom_range(200, 262) : (r < 10) ? $urandom_range(9, 40) :
            $urandom_range(0, 10);
        if ($urandom_range(0, 1)) begin
            add_byte(qlfs_pkg::CH_QUOTE);
            repeat (n) begin
                r = $urandom_range(0, 9);
                if (r == 0) begin
                    add_byte(qlfs_pkg::CH_QUOTE);
                    add_byte(qlfs_pkg::CH_QUOTE);
                end else if (r == 1)
                    add_byte(qlfs_pkg::CH_COMMA);
                else
                    add_byte(rnd_char());
            end
            add_byte(qlfs_pkg::CH_QUOTE);
            if ($urandom_range(0, 4) == 0)
                add_byte(rnd_char());
        end else
            repeat (n) add_byte(rnd_char());
        repeat ($urandom_range(0, 2)) add_byte(rnd_blank());
    endtask

    task automatic gen_list();
        int nf;
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 6) begin
            repeat ($urandom_range(1, 12)) add_byte(8'($urandom_range(0, 255)));
            add_byte(qlfs_pkg::CH_END);
        end else if (roll < 10) begin
            add_byte(qlfs_pkg::CH_QUOTE);
            repeat ($urandom_range(0, 6)) add_byte(rnd_char());
            add_byte(qlfs_pkg::CH_END);
        end else begin
            nf = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 34) : $urandom_range(1, 5);
            for (int f = 0; f < nf; f++) begin
                if (f != 0)
                    add_byte(qlfs_pkg::CH_COMMA);
                add_field();
            end
            add_byte(qlfs_pkg::CH_END);
        end
    endtask

    task automatic run_phase(input int len_cfg, input int items_cfg, input int idle_pct,
                             input int stall_cfg, input bit squeeze);
        int start;
        write_reg(qlfs_pkg::CFG_MAX_LEN, 8'(len_cfg));
        write_reg(qlfs_pkg::CFG_MAX_ITEMS, 8'(items_cfg));
        send_idle_pct = idle_pct;
        stall_pct    <= stall_cfg;
        if (squeeze)
            hold_seq <= hold_seq + 1;
        start = sent_cnt;
        while (sent_cnt - start < PHASE_BYTES) begin
            gen_list();
            send_text();
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed lists at reset limits
        add_str(" hi , 'a, b''c' ,x");
        add_byte(qlfs_pkg::CH_END);
        add_str("' pad '");
        add_byte(qlfs_pkg::CH_END);
        add_str("'ab'cd");                     // string closes on a plain byte
        add_byte(qlfs_pkg::CH_END);
        add_str("'ab'");                       // pending quote then end byte
        add_byte(qlfs_pkg::CH_END);
        add_str(",a,b");                       // empty first field, rest dropped
        add_byte(qlfs_pkg::CH_END);
        add_str("a,");                         // error on the end byte itself
        add_byte(qlfs_pkg::CH_END);
        add_str("z");
        add_byte(qlfs_pkg::CH_END);
        add_byte(qlfs_pkg::CH_END);
        add_str("'abc");                       // unterminated string
        add_byte(qlfs_pkg::CH_END);
        for (int b = 9; b <= 13; b++)
            add_byte(8'(b));
        add_str(" x");
        add_byte(8'hFF);
        add_byte(8'h80);
        add_byte(8'h01);
        add_byte(8'h7F);
        add_byte(8'h20);
        add_byte(qlfs_pkg::CH_END);
        repeat (255) add_byte("q");            // longest field: 32 chunks
        add_byte(qlfs_pkg::CH_END);
        repeat (256) add_byte("b");            // token buffer overflows
        add_byte(qlfs_pkg::CH_END);
        for (int k = 0; k < 33; k++) begin
            add_str("a");
            add_byte((k == 32) ? qlfs_pkg::CH_END : qlfs_pkg::CH_COMMA);
        end
        send_text();

        // zero limits
        write_reg(qlfs_pkg::CFG_MAX_LEN, 8'd0);
        add_str("ab,");
        add_byte(qlfs_pkg::CH_END);
        add_str(" ,x");
        add_byte(qlfs_pkg::CH_END);
        send_text();
        write_reg(qlfs_pkg::CFG_MAX_LEN, 8'd255);
        write_reg(qlfs_pkg::CFG_MAX_ITEMS, 8'd0);
        add_str("x,y");
        add_byte(qlfs_pkg::CH_END);
        send_text();
        write_reg(qlfs_pkg::CFG_MAX_ITEMS, 8'd63);
        add_str("m,n");
        add_byte(qlfs_pkg::CH_END);
        send_text();

        // random lists under several limits and flow-control patterns
        run_phase(255, 32, 0, 0, 1'b1);
        run_phase(8, 4, 88, 0, 1'b0);
        run_phase(1, 1, 0, 88, 1'b0);
        run_phase(255, 32, 13, 13, 1'b0);
        run_phase($urandom_range(1, 255), $urandom_range(1, 32), 13, 13, 1'b0);

        drain();
        if (sb.fail_cnt == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== quoted_list_field_splitter_unit.f =====
hdl/qlfs_pkg.sv
hdl/qlfs_scan.sv
hdl/qlfs_chunk_rd.sv
hdl/quoted_list_field_splitter_unit.sv
tb/testbench.sv
